// ----- rtl/plol_pkg.sv -----
// Shared constants, types and state codes for the piecewise-linear opacity lookup.
// No dependencies; used by plol_div and the core, not by plol_ram.
package plol_pkg;

	localparam int MAX_KNOTS  = 1024;
	localparam int IDX_W      = $clog2(MAX_KNOTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int FRAC_BITS  = 16;
	localparam int VAL_W      = FRAC_BITS + 1;
	localparam int PROD_W     = 2 * VAL_W;
	localparam int DIV_CNT_W  = $clog2(VAL_W + 1);
	localparam int KNOT_W     = 2 * VAL_W;

	// slave tdata: knot_index, knot_scalar, knot_alpha, query_value from bit 0 up
	localparam int IDX_LSB    = 0;
	localparam int SCL_LSB    = IDX_LSB + IDX_W;
	localparam int ALP_LSB    = SCL_LSB + VAL_W;
	localparam int QRY_LSB    = ALP_LSB + VAL_W;
	localparam int S_FIELDS_W = QRY_LSB + VAL_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((VAL_W + 7) / 8) * 8;

	localparam logic [VAL_W-1:0] ONE_VALUE = VAL_W'(1) << FRAC_BITS;
	localparam logic [CNT_W-1:0] MAX_KNOTS_C = CNT_W'(MAX_KNOTS);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0] scalar;
		logic [VAL_W-1:0] alpha;
	} knot_t;

	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] dividend;
		logic [VAL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             rem_nz;
		logic [VAL_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} plol_state_t;

endpackage

// ----- rtl/plol_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plol_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/plol_div.sv -----
// Restoring serial divider, one quotient bit per cycle, VAL_W steps.
// Depends on plol_pkg; the quotient is known to fit VAL_W bits.
module plol_div (
	input  logic              clk,
	input  logic              arst_n,
	input  plol_pkg::div_req_t req,
	output plol_pkg::div_rsp_t rsp
);

	logic [plol_pkg::VAL_W-1:0]     rem_q;
	logic [plol_pkg::VAL_W-1:0]     lo_q;
	logic [plol_pkg::VAL_W-1:0]     den_q;
	logic [plol_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           active_q;
	logic [plol_pkg::VAL_W:0]       sh;
	logic [plol_pkg::VAL_W:0]       den_x;
	logic                           ge;
	logic [plol_pkg::VAL_W-1:0]     rem_nx;

	assign sh     = {rem_q, lo_q[plol_pkg::VAL_W-1]};
	assign den_x  = {1'b0, den_q};
	assign ge     = (sh >= den_x);
	assign rem_nx = ge ? plol_pkg::VAL_W'(sh - den_x) : sh[plol_pkg::VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (req.start) begin
			active_q <= 1'b1;
			cnt_q    <= plol_pkg::DIV_CNT_W'(plol_pkg::VAL_W);
		end else if (active_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				active_q <= 1'b0;
			end
		end
	end

	// dividend high half is below the divisor, so it seeds the remainder
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[plol_pkg::PROD_W-1:plol_pkg::VAL_W];
			lo_q  <= req.dividend[plol_pkg::VAL_W-1:0];
			den_q <= req.divisor;
		end else if (active_q && cnt_q != '0) begin
			rem_q <= rem_nx;
			lo_q  <= {lo_q[plol_pkg::VAL_W-2:0], ge};
		end
	end

	assign rsp.done   = active_q && (cnt_q == '0);
	assign rsp.rem_nz = |rem_q;
	assign rsp.quot   = lo_q;

endmodule

// ----- rtl/piecewise_linear_opacity_lookup_core.sv -----
// Piecewise-linear opacity lookup: knot table, linear segment scan, serial divide.
// Depends on plol_pkg, plol_ram and plol_div.
// Writes, out-of-range queries and empty-table queries go straight to the result stage; a clamped
// query reads the first and, if needed, the last knot; an interpolation makes one read per scanned
// knot up to segment end j, then multiplies and divides. One in flight; ready again once the result loads.
// Reset clears the sequencer, knot_count and the output valid; the knot table is not reset.
module piecewise_linear_opacity_lookup_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [plol_pkg::CNT_W-1:0]      cfg_wdata,     // knot_count
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [plol_pkg::S_TDATA_W-1:0]  s_tdata,       // knot_index, knot_scalar, knot_alpha, query_value
	input  logic [0:0]                      s_tuser,       // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [plol_pkg::M_TDATA_W-1:0]  m_tdata,       // opacity
	output logic [0:0]                      m_tuser        // status
);

	plol_pkg::plol_state_t state_q, state_d;

	logic [plol_pkg::CNT_W-1:0] knot_count_q;
	logic [plol_pkg::IDX_W-1:0] nm1;
	logic                       tbl_empty;

	// request fields
	logic                       in_type;
	logic [plol_pkg::IDX_W-1:0] in_index;
	logic [plol_pkg::VAL_W-1:0] in_scalar;
	logic [plol_pkg::VAL_W-1:0] in_alpha;
	logic [plol_pkg::VAL_W-1:0] in_value;
	logic                       accept;
	logic                       in_range_err;

	// table
	logic                       ram_we;
	logic [plol_pkg::IDX_W-1:0] ram_raddr;
	logic [plol_pkg::KNOT_W-1:0] ram_rdata;
	plol_pkg::knot_t            rd_knot;

	// datapath
	logic [plol_pkg::VAL_W-1:0] v_q;
	plol_pkg::knot_t            prev_q;
	plol_pkg::knot_t            cur_q;
	logic [plol_pkg::IDX_W-1:0] j_q;
	logic [plol_pkg::VAL_W-1:0] num_q;
	logic [plol_pkg::VAL_W-1:0] den_q;
	logic [plol_pkg::VAL_W-1:0] diff_q;
	logic                       neg_q;
	logic [plol_pkg::VAL_W-1:0] res_q;
	logic                       status_q;
	logic                       found;

	plol_pkg::div_req_t         div_req;
	plol_pkg::div_rsp_t         div_rsp;

	// output register
	logic                       m_tvalid_q;
	logic [plol_pkg::VAL_W-1:0] opacity_q;
	logic                       m_status_q;
	logic                       out_load;

	assign in_type   = s_tuser[0];
	assign in_index  = s_tdata[plol_pkg::IDX_LSB +: plol_pkg::IDX_W];
	assign in_scalar = s_tdata[plol_pkg::SCL_LSB +: plol_pkg::VAL_W];
	assign in_alpha  = s_tdata[plol_pkg::ALP_LSB +: plol_pkg::VAL_W];
	assign in_value  = s_tdata[plol_pkg::QRY_LSB +: plol_pkg::VAL_W];

	assign s_tready     = (state_q == plol_pkg::ST_IDLE);
	assign accept       = s_tvalid && s_tready;
	assign in_range_err = (in_value > plol_pkg::ONE_VALUE);

	// knot count: anything at or above the table size means a full table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			knot_count_q <= '0;
		end else if (cfg_we) begin
			knot_count_q <= cfg_wdata;
		end
	end

	assign tbl_empty = (knot_count_q == '0);
	assign nm1 = (knot_count_q >= plol_pkg::MAX_KNOTS_C) ?
		plol_pkg::IDX_W'(plol_pkg::MAX_KNOTS - 1) :
		plol_pkg::IDX_W'(knot_count_q - 1'b1);

	// scalar and alpha share one entry, written together
	assign ram_we = accept && (in_type == plol_pkg::REQ_WRITE);

	plol_ram #(
		.WIDTH (plol_pkg::KNOT_W),
		.DEPTH (plol_pkg::MAX_KNOTS)
	) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_index),
		.wdata ({in_scalar, in_alpha}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_knot = plol_pkg::knot_t'(ram_rdata);

	// segment end: first knot above v, or the last knot which is known to be above v
	assign found = (rd_knot.scalar > v_q) || (j_q == nm1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= plol_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_raddr = '0;
		out_load  = 1'b0;
		unique case (state_q)
			plol_pkg::ST_IDLE: begin
				ram_raddr = '0;
				if (accept) begin
					if (in_type == plol_pkg::REQ_WRITE || in_range_err || tbl_empty) begin
						state_d = plol_pkg::ST_FIN;
					end else begin
						state_d = plol_pkg::ST_FIRST;
					end
				end
			end
			plol_pkg::ST_FIRST: begin
				ram_raddr = nm1;
				state_d = (v_q <= rd_knot.scalar) ? plol_pkg::ST_FIN : plol_pkg::ST_LAST;
			end
			plol_pkg::ST_LAST: begin
				ram_raddr = plol_pkg::IDX_W'(1);
				state_d = (v_q >= rd_knot.scalar) ? plol_pkg::ST_FIN : plol_pkg::ST_SCAN;
			end
			plol_pkg::ST_SCAN: begin
				ram_raddr = j_q + 1'b1;
				if (found) begin
					state_d = plol_pkg::ST_PREP;
				end
			end
			plol_pkg::ST_PREP: begin
				state_d = plol_pkg::ST_MUL;
			end
			plol_pkg::ST_MUL: begin
				state_d = plol_pkg::ST_DIV;
			end
			plol_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = plol_pkg::ST_FIN;
				end
			end
			plol_pkg::ST_FIN: begin
				out_load = !m_tvalid_q || m_tready;
				if (out_load) begin
					state_d = plol_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = plol_pkg::ST_IDLE;
			end
		endcase
	end

	// product goes straight into the divider's registers
	assign div_req.start    = (state_q == plol_pkg::ST_MUL);
	assign div_req.dividend = plol_pkg::PROD_W'(diff_q) * plol_pkg::PROD_W'(num_q);
	assign div_req.divisor  = den_q;

	plol_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// datapath registers; result defaults to zero for writes, errors and empty tables
	always_ff @(posedge clk) begin
		case (state_q)
			plol_pkg::ST_IDLE: begin
				if (accept) begin
					v_q      <= in_value;
					res_q    <= '0;
					status_q <= (in_type == plol_pkg::REQ_QUERY && in_range_err) ?
						plol_pkg::STATUS_RANGE : plol_pkg::STATUS_OK;
				end
			end
			plol_pkg::ST_FIRST: begin
				prev_q <= rd_knot;
				if (v_q <= rd_knot.scalar) begin
					res_q <= rd_knot.alpha;
				end
			end
			plol_pkg::ST_LAST: begin
				j_q <= plol_pkg::IDX_W'(1);
				if (v_q >= rd_knot.scalar) begin
					res_q <= rd_knot.alpha;
				end
			end
			plol_pkg::ST_SCAN: begin
				if (found) begin
					cur_q <= rd_knot;
				end else begin
					prev_q <= rd_knot;
					j_q    <= j_q + 1'b1;
				end
			end
			plol_pkg::ST_PREP: begin
				num_q <= v_q - prev_q.scalar;
				den_q <= cur_q.scalar - prev_q.scalar;
				neg_q <= (cur_q.alpha < prev_q.alpha);
				diff_q <= (cur_q.alpha < prev_q.alpha) ? (prev_q.alpha - cur_q.alpha) :
					(cur_q.alpha - prev_q.alpha);
			end
			plol_pkg::ST_DIV: begin
				// falling segment: round the magnitude up so the result floors
				if (div_rsp.done) begin
					res_q <= neg_q ?
						(prev_q.alpha - (div_rsp.quot + plol_pkg::VAL_W'(div_rsp.rem_nz))) :
						(prev_q.alpha + div_rsp.quot);
				end
			end
			default: begin
			end
		endcase
	end

	// output register: holds a result while the next request is worked on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			opacity_q  <= res_q;
			m_status_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = plol_pkg::M_TDATA_W'(opacity_q);
	assign m_tuser  = m_status_q;

	// scan never runs past the last knot
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == plol_pkg::ST_SCAN |-> j_q <= nm1)
		else $error("segment scan beyond last knot");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == plol_pkg::ST_DIV)
		else $error("divider done outside divide state");

	// out-of-range results carry zero opacity
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0] == plol_pkg::STATUS_RANGE) |-> opacity_q == '0)
		else $error("range error with non-zero opacity");

	// a result is loaded only when the output register is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("pending result overwritten");

endmodule
